// ----- rtl/dlrr_pkg.sv -----
// ---------------------------------------------------------------------------
// dlrr_pkg
// Shared constants and types for the downmix and linear resampler block.
// ---------------------------------------------------------------------------
package dlrr_pkg;

    localparam int NUM_CH         = 8;
    localparam int MAX_CHANNELS   = 8;
    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 19;
    localparam int CC_W           = 4;
    localparam int IN_RATE_W      = 18;
    localparam int OUT_RATE_W     = 16;
    localparam int OIDX_W         = 20;
    localparam int RING_AW        = 19;

    localparam logic [OIDX_W-1:0] OIDX_MAX = '1;

    localparam int IN_TDATA_W     = NUM_CH * SAMPLE_W;
    localparam int OUT_TDATA_W    = 40;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 18;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_RATE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE = 2'd3;

    localparam int RING_DEPTH_DEF = 524288;
    localparam int MAX_BLOCK_DEF  = 65536;

    localparam int DIV_DVD_W      = 38;
    localparam int DIV_DVS_W      = 18;
    localparam int DIV_CNT_W      = 6;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
        logic [DIV_DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ----- rtl/dlrr_div.sv -----
// ---------------------------------------------------------------------------
// dlrr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dlrr_div
    import dlrr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;

    logic [DIV_CNT_W-1:0] shamt;
    logic [DIV_DVS_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DVS_W:0]   rem_sub;

    assign shamt   = DIV_CNT_W'(DIV_DVD_W) - req.steps;
    assign rem_sh  = {rem_reg, dvd_reg[DIV_DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend << shamt;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- rtl/downmix_linear_resample_ring.sv -----
// ---------------------------------------------------------------------------
// downmix_linear_resample_ring
// Mono downmix and linear-interpolation resampler that tags each output
// sample with a wrapping ring write address.
// ---------------------------------------------------------------------------
// The block takes one frame at a time and is not ready again until the frame
// is fully processed. All multiplications and divisions run through one shared
// multiplier and one divider that produces a quotient bit per cycle. Per frame
// the divider works out the channel average, then two divisions for the output
// range of the frame, then one division for each output sample taken straight
// from a frame and a second for each interpolated one (at most eight outputs
// per frame), and when needed more to prepare a sample held for the next frame.
// A finished output transfer waits in the output register and does not hold
// up the next input transfer.
// ---------------------------------------------------------------------------
module downmix_linear_resample_ring
    import dlrr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int MAX_BLOCK  = MAX_BLOCK_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7 (16 bits each)
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mono_out (16 bits), ring_address (19 bits), zero padding
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int FW       = $clog2(MAX_BLOCK);
    localparam int RPW      = $clog2(RING_DEPTH);
    localparam int MUL_A_W  = OIDX_W + 1;
    localparam int MUL_B_W  = IN_RATE_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 34;
    localparam int OUT_PAD  = OUT_TDATA_W - SAMPLE_W - RING_AW;

    localparam logic [FW-1:0]        MAX_F      = FW'(MAX_BLOCK - 1);
    localparam logic [RPW-1:0]       RING_LAST  = RPW'(RING_DEPTH - 1);
    localparam logic [DIV_CNT_W-1:0] MEAN_STEPS = DIV_CNT_W'(SUM_W);
    localparam logic [DIV_CNT_W-1:0] CL_STEPS   = DIV_CNT_W'(FW + 17);
    localparam logic [DIV_CNT_W-1:0] Q_STEPS    = DIV_CNT_W'(DIV_DVD_W);
    localparam logic [DIV_CNT_W-1:0] BL_STEPS   = DIV_CNT_W'(32);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MEAN     = 5'd1;
    localparam logic [4:0] S_MEAN_W   = 5'd2;
    localparam logic [4:0] S_CEIL_MUL = 5'd3;
    localparam logic [4:0] S_CEIL_DIV = 5'd4;
    localparam logic [4:0] S_CEIL_W   = 5'd5;
    localparam logic [4:0] S_LIM_MUL  = 5'd6;
    localparam logic [4:0] S_LIM_DIV  = 5'd7;
    localparam logic [4:0] S_LIM_W    = 5'd8;
    localparam logic [4:0] S_STOP     = 5'd9;
    localparam logic [4:0] S_LOOP     = 5'd10;
    localparam logic [4:0] S_Q_MUL    = 5'd11;
    localparam logic [4:0] S_Q_DIV    = 5'd12;
    localparam logic [4:0] S_Q_W      = 5'd13;
    localparam logic [4:0] S_BL_MUL1  = 5'd14;
    localparam logic [4:0] S_BL_MUL2  = 5'd15;
    localparam logic [4:0] S_BL_SUM   = 5'd16;
    localparam logic [4:0] S_BL_W     = 5'd17;
    localparam logic [4:0] S_EMIT     = 5'd18;
    localparam logic [4:0] S_UPDATE   = 5'd19;
    localparam logic [4:0] S_H_MUL    = 5'd20;
    localparam logic [4:0] S_H_CMP    = 5'd21;
    localparam logic [4:0] S_H_W      = 5'd22;
    localparam logic [4:0] S_COMMIT   = 5'd23;

    logic [4:0]                 state_reg;
    logic [CC_W-1:0]            cc_reg;
    logic [IN_RATE_W-1:0]       inr_reg;
    logic [OUT_RATE_W-1:0]      outr_reg;
    logic                       cap_reg;

    logic signed [SAMPLE_W-1:0] prev_reg;
    logic [FW-1:0]              f_reg;
    logic [OIDX_W-1:0]          oidx_reg;
    logic [RPW-1:0]             ring_reg;
    logic                       hold_valid_reg;
    logic [SAMPLE_W-1:0]        hold_reg;

    logic signed [SUM_W-1:0]    sum_reg;
    logic [CC_W-1:0]            nch_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] m_reg;
    logic [FW+15:0]             fo_reg;
    logic [OIDX_W-1:0]          ceil_reg;
    logic [OIDX_W-1:0]          lim_reg;
    logic [OIDX_W-1:0]          stop_reg;
    logic [OIDX_W-1:0]          i_reg;
    logic [3:0]                 k_reg;
    logic [OUT_RATE_W-1:0]      r_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic                       bl_hold_reg;
    logic [SAMPLE_W-1:0]        v_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic                       mv_reg;
    logic [SAMPLE_W-1:0]        mono_out_reg;
    logic [RING_AW-1:0]         addr_out_reg;
    logic                       run_last_reg;

    logic [CC_W-1:0]            nch_w;
    logic signed [SUM_W-1:0]    sum_w;
    logic [IN_RATE_W-1:0]       inr_eff;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic [SUM_W-1:0]           sum_abs;
    logic signed [ACC_W-1:0]    num_w;
    logic [ACC_W-1:0]           num_abs;
    logic [DIV_DVD_W-1:0]       prod_u;
    logic                       h_need;
    logic [FW-1:0]              f_m1;
    logic                       f_nz;
    logic [DIV_DVD_W-1:0]       quot;
    logic [OIDX_W-1:0]          quot_c;
    logic [SAMPLE_W-1:0]        q16;
    logic [SAMPLE_W-1:0]        mean_val;
    logic [SAMPLE_W-1:0]        bl_val;
    logic                       out_free;
    logic                       emit_last;
    logic [RPW+RING_AW-1:0]     ring_ext;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    dlrr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign inr_eff = (inr_reg == '0) ? IN_RATE_W'(1) : inr_reg;

    always_comb begin
        if (cc_reg == '0) begin
            nch_w = CC_W'(1);
        end else if (cc_reg > CC_W'(MAX_CHANNELS)) begin
            nch_w = CC_W'(MAX_CHANNELS);
        end else begin
            nch_w = cc_reg;
        end
    end

    always_comb begin
        sum_w = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (CC_W'(ch) < nch_w) begin
                sum_w = sum_w + SUM_W'($signed(s_tdata[ch*SAMPLE_W +: SAMPLE_W]));
            end
        end
    end

    assign sum_abs  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num_w    = acc_reg + $signed(prod_reg[ACC_W-1:0]);
    assign num_abs  = num_w[ACC_W-1] ? ACC_W'(-num_w) : ACC_W'(num_w);
    assign prod_u   = prod_reg[DIV_DVD_W-1:0];
    assign h_need   = prod_u < DIV_DVD_W'(fo_reg);
    assign f_m1     = f_reg - FW'(1);
    assign f_nz     = f_reg != '0;
    assign quot     = div_rsp.quotient;
    assign quot_c   = (quot > DIV_DVD_W'(OIDX_MAX)) ? OIDX_MAX : quot[OIDX_W-1:0];
    assign q16      = quot[SAMPLE_W-1:0];
    assign mean_val = sum_reg[SUM_W-1] ? (SAMPLE_W'(0) - q16) : q16;
    assign bl_val   = neg_reg ? (SAMPLE_W'(0) - q16) : q16;
    assign out_free = !mv_reg || m_tready;
    assign emit_last = ((i_reg + OIDX_W'(1)) == stop_reg) || (k_reg == 4'd7);
    assign ring_ext = {{RING_AW{1'b0}}, ring_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_CEIL_MUL: begin
                mul_a = MUL_A_W'(f_reg);
                mul_b = MUL_B_W'(outr_reg);
            end
            S_LIM_MUL: begin
                mul_a = MUL_A_W'(f_reg) + MUL_A_W'(1);
                mul_b = MUL_B_W'(outr_reg);
            end
            S_Q_MUL: begin
                mul_a = MUL_A_W'(i_reg);
                mul_b = MUL_B_W'(inr_eff);
            end
            S_BL_MUL1: begin
                mul_a = MUL_A_W'(prev_reg);
                mul_b = MUL_B_W'(outr_reg - r_reg);
            end
            S_BL_MUL2: begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(r_reg);
            end
            S_H_MUL: begin
                mul_a = MUL_A_W'(oidx_reg);
                mul_b = MUL_B_W'(inr_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.steps    = Q_STEPS;
        div_req.dividend = prod_u;
        div_req.divisor  = DIV_DVS_W'(outr_reg);
        case (state_reg)
            S_MEAN: begin
                div_req.start    = 1'b1;
                div_req.steps    = MEAN_STEPS;
                div_req.dividend = DIV_DVD_W'(sum_abs);
                div_req.divisor  = DIV_DVS_W'(nch_reg);
            end
            S_CEIL_DIV: begin
                div_req.start    = 1'b1;
                div_req.steps    = CL_STEPS;
                div_req.dividend = prod_u + DIV_DVD_W'(inr_eff) - DIV_DVD_W'(1);
                div_req.divisor  = inr_eff;
            end
            S_LIM_DIV: begin
                div_req.start    = 1'b1;
                div_req.steps    = CL_STEPS;
                div_req.divisor  = inr_eff;
            end
            S_Q_DIV: begin
                div_req.start    = 1'b1;
            end
            S_BL_SUM: begin
                div_req.start    = 1'b1;
                div_req.steps    = BL_STEPS;
                div_req.dividend = DIV_DVD_W'(num_abs[31:0]);
            end
            S_H_CMP: begin
                div_req.start    = h_need;
            end
            default: begin
                div_req.start    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cc_reg         <= CC_W'(2);
            inr_reg        <= IN_RATE_W'(48000);
            outr_reg       <= OUT_RATE_W'(16000);
            cap_reg        <= 1'b1;
            prev_reg       <= '0;
            f_reg          <= '0;
            oidx_reg       <= '0;
            ring_reg       <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
            mv_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CHANNEL_COUNT:  cc_reg   <= cfg_wdata[CC_W-1:0];
                    REG_IN_RATE:        inr_reg  <= cfg_wdata[IN_RATE_W-1:0];
                    REG_OUT_RATE:       outr_reg <= cfg_wdata[OUT_RATE_W-1:0];
                    REG_CAPTURE_ENABLE: cap_reg  <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end

            if (mv_reg && m_tready) begin
                mv_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        sum_reg   <= sum_w;
                        nch_reg   <= nch_w;
                        last_reg  <= s_tlast || (f_reg == MAX_F);
                        state_reg <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    state_reg <= S_MEAN_W;
                end
                S_MEAN_W: begin
                    if (div_rsp.done) begin
                        m_reg <= $signed(mean_val);
                        if (outr_reg == '0) begin
                            stop_reg  <= '0;
                            state_reg <= S_UPDATE;
                        end else begin
                            state_reg <= S_CEIL_MUL;
                        end
                    end
                end
                S_CEIL_MUL: begin
                    state_reg <= S_CEIL_DIV;
                end
                S_CEIL_DIV: begin
                    fo_reg    <= prod_u[FW+15:0];
                    state_reg <= S_CEIL_W;
                end
                S_CEIL_W: begin
                    if (div_rsp.done) begin
                        ceil_reg  <= quot_c;
                        state_reg <= S_LIM_MUL;
                    end
                end
                S_LIM_MUL: begin
                    state_reg <= S_LIM_DIV;
                end
                S_LIM_DIV: begin
                    state_reg <= S_LIM_W;
                end
                S_LIM_W: begin
                    if (div_rsp.done) begin
                        lim_reg   <= quot_c;
                        state_reg <= S_STOP;
                    end
                end
                S_STOP: begin
                    if (last_reg || (lim_reg < ceil_reg)) begin
                        stop_reg <= lim_reg;
                    end else begin
                        stop_reg <= ceil_reg;
                    end
                    i_reg     <= oidx_reg;
                    k_reg     <= '0;
                    state_reg <= S_LOOP;
                end
                S_LOOP: begin
                    if ((i_reg < stop_reg) && !k_reg[3]) begin
                        if (hold_valid_reg) begin
                            v_reg          <= hold_reg;
                            hold_valid_reg <= 1'b0;
                            state_reg      <= S_EMIT;
                        end else begin
                            state_reg <= S_Q_MUL;
                        end
                    end else begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_Q_MUL: begin
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV: begin
                    state_reg <= S_Q_W;
                end
                S_Q_W: begin
                    if (div_rsp.done) begin
                        r_reg <= div_rsp.remainder[OUT_RATE_W-1:0];
                        if (quot >= DIV_DVD_W'(f_reg)) begin
                            v_reg     <= m_reg;
                            state_reg <= S_EMIT;
                        end else if (f_nz && (quot == DIV_DVD_W'(f_m1))) begin
                            bl_hold_reg <= 1'b0;
                            state_reg   <= S_BL_MUL1;
                        end else begin
                            v_reg     <= prev_reg;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_BL_MUL1: begin
                    state_reg <= S_BL_MUL2;
                end
                S_BL_MUL2: begin
                    acc_reg   <= $signed(prod_reg[ACC_W-1:0]);
                    state_reg <= S_BL_SUM;
                end
                S_BL_SUM: begin
                    neg_reg   <= num_w[ACC_W-1];
                    state_reg <= S_BL_W;
                end
                S_BL_W: begin
                    if (div_rsp.done) begin
                        if (bl_hold_reg) begin
                            hold_reg       <= bl_val;
                            hold_valid_reg <= 1'b1;
                            state_reg      <= S_COMMIT;
                        end else begin
                            v_reg     <= bl_val;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!cap_reg || out_free) begin
                        if (cap_reg) begin
                            mv_reg       <= 1'b1;
                            mono_out_reg <= v_reg;
                            addr_out_reg <= ring_ext[RING_AW-1:0];
                            run_last_reg <= emit_last;
                            ring_reg     <= (ring_reg == RING_LAST) ? '0 : ring_reg + 1'b1;
                        end
                        i_reg     <= i_reg + OIDX_W'(1);
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_LOOP;
                    end
                end
                S_UPDATE: begin
                    if (last_reg) begin
                        oidx_reg       <= '0;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_COMMIT;
                    end else if (stop_reg > oidx_reg) begin
                        oidx_reg       <= stop_reg;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_H_MUL;
                    end else if (!hold_valid_reg && (outr_reg != '0)) begin
                        state_reg <= S_H_MUL;
                    end else begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_H_MUL: begin
                    state_reg <= S_H_CMP;
                end
                S_H_CMP: begin
                    if (h_need) begin
                        state_reg <= S_H_W;
                    end else begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_H_W: begin
                    if (div_rsp.done) begin
                        r_reg <= div_rsp.remainder[OUT_RATE_W-1:0];
                        if (f_nz && (quot == DIV_DVD_W'(f_m1))) begin
                            bl_hold_reg <= 1'b1;
                            state_reg   <= S_BL_MUL1;
                        end else begin
                            hold_reg       <= prev_reg;
                            hold_valid_reg <= 1'b1;
                            state_reg      <= S_COMMIT;
                        end
                    end
                end
                S_COMMIT: begin
                    f_reg     <= last_reg ? '0 : f_reg + FW'(1);
                    prev_reg  <= m_reg;
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, addr_out_reg, mono_out_reg};
    assign m_tlast  = run_last_reg;

endmodule

// ----- tb/tb_downmix_linear_resample_ring.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_downmix_linear_resample_ring
// Self-checking bench for the downmix and linear resampler. A directed table
// of frames and register writes runs first. Random phases follow, each with
// its own register setting, with one block long enough to overrun. Every
// accepted output transfer is compared with a table entry or a local predictor.
// ---------------------------------------------------------------------------
module tb_downmix_linear_resample_ring;
    import dlrr_pkg::*;

    localparam int RING_LEN      = 1024;
    localparam int BLOCK_LEN     = 256;
    localparam int SETTLE_CYCLES = 1000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 30;

    typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_e;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mono;
        logic [RING_AW-1:0]  addr;
        logic                last;
    } sample_t;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [IN_TDATA_W-1:0] frame;
        bit                    blk_end;
        bit                    typed;
        sample_t               want;
    } step_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    logic [CC_W-1:0]        cfg_channels;
    logic [IN_RATE_W-1:0]   cfg_in_rate;
    logic [OUT_RATE_W-1:0]  cfg_out_rate;
    logic                   cfg_capture;

    int      mono_prev;
    longint  frame_pos;
    longint  out_pos;
    int      ring_ptr;
    bit      held_valid;
    int      held_sample;
    bit      overrun_seen;

    sample_t   pending_samples[$];
    sample_t   frame_outputs[$];
    step_row_t rows[$];
    sample_t   head;
    int        mismatch_count;
    bit        quiet;
    bit        hold_req;

    downmix_linear_resample_ring #(
        .RING_DEPTH (RING_LEN),
        .MAX_BLOCK  (BLOCK_LEN)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int lerp(int a, int b, longint r, longint den);
        longint num;
        num = longint'(a) * (den - r) + longint'(b) * r;
        return int'(num / den);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] chans(int c0, int c1 = 0, int c2 = 0,
            int c3 = 0, int c4 = 0, int c5 = 0, int c6 = 0, int c7 = 0);
        return {16'(c7), 16'(c6), 16'(c5), 16'(c4), 16'(c3), 16'(c2), 16'(c1), 16'(c0)};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] all_chans(int v);
        return chans(v, v, v, v, v, v, v, v);
    endfunction

    function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
        step_row_t row;
        row = '{kind: ROW_CFG, reg_idx: idx, value: CFG_DATA_W'(val), frame: '0,
                blk_end: 1'b0, typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic step_row_t frame_row(logic [IN_TDATA_W-1:0] fr, bit e,
            bit typed = 1'b0, int mono = 0, int addr = 0);
        step_row_t row;
        row = '{kind: ROW_FRAME, reg_idx: REG_CHANNEL_COUNT, value: '0, frame: fr,
                blk_end: e, typed: typed,
                want: '{mono: SAMPLE_W'(mono), addr: RING_AW'(addr), last: 1'b1}};
        return row;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_frame();
        logic [IN_TDATA_W-1:0] fr;
        for (int k = 0; k < NUM_CH; k++) begin
            case ($urandom_range(0, 5))
                0: fr[16*k +: 16] = 16'h8000;
                1: fr[16*k +: 16] = 16'h7FFF;
                2: fr[16*k +: 16] = 16'($urandom_range(0, 15)) - 16'd8;
                default: fr[16*k +: 16] = 16'($urandom);
            endcase
        end
        return fr;
    endfunction

    // Mono average, output range of the frame, interpolation and ring tagging.
    task automatic downmix_resample(input logic [IN_TDATA_W-1:0] frame, input bit blk_end);
        int     nch, sum, m, n;
        int     vals[8];
        longint inr, outr, f, lim, stop, ceilv, i, q, idx, r;
        bit     last;
        nch = (cfg_channels == 0) ? 1 :
              ((cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg_channels));
        sum = 0;
        n = 0;
        lim = 0;
        stop = 0;
        inr = (cfg_in_rate == 0) ? 1 : longint'(cfg_in_rate);
        outr = longint'(cfg_out_rate);
        f = frame_pos;
        for (int k = 0; k < nch; k++) begin
            sum += int'($signed(frame[16*k +: 16]));
        end
        m = sum / nch;
        last = blk_end || (f + 1 >= BLOCK_LEN);
        if (last && !blk_end) begin
            overrun_seen = 1'b1;
        end
        if (outr != 0) begin
            ceilv = (f * outr + inr - 1) / inr;
            lim = (f + 1) * outr / inr;
            stop = last ? lim : ((lim < ceilv) ? lim : ceilv);
            if (stop > longint'(OIDX_MAX)) begin
                stop = longint'(OIDX_MAX);
            end
        end
        i = out_pos;
        while (i < stop && n < 8) begin
            if (held_valid) begin
                vals[n] = held_sample;
                held_valid = 1'b0;
            end else begin
                q = i * inr;
                idx = q / outr;
                r = q % outr;
                if (idx >= f) begin
                    vals[n] = m;
                end else if (idx + 1 == f) begin
                    vals[n] = lerp(mono_prev, m, r, outr);
                end else begin
                    vals[n] = mono_prev;
                end
            end
            n++;
            i++;
        end
        if (stop > out_pos) begin
            held_valid = 1'b0;
            out_pos = stop;
        end
        if (last) begin
            frame_pos = 0;
            out_pos = 0;
            held_valid = 1'b0;
        end else begin
            if (!held_valid && outr != 0) begin
                q = out_pos * inr;
                if (q < f * outr) begin
                    idx = q / outr;
                    r = q % outr;
                    held_sample = (idx + 1 == f) ? lerp(mono_prev, m, r, outr) : mono_prev;
                    held_valid = 1'b1;
                end
            end
            frame_pos = f + 1;
        end
        mono_prev = m;
        frame_outputs.delete();
        if (cfg_capture) begin
            for (int k = 0; k < n; k++) begin
                frame_outputs.push_back('{mono: vals[k][15:0], addr: ring_ptr[18:0],
                                          last: (k == n - 1)});
                ring_ptr = (ring_ptr + 1) % RING_LEN;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CHANNEL_COUNT:  cfg_channels = val[CC_W-1:0];
            REG_IN_RATE:        cfg_in_rate  = val[IN_RATE_W-1:0];
            REG_OUT_RATE:       cfg_out_rate = val[OUT_RATE_W-1:0];
            REG_CAPTURE_ENABLE: cfg_capture  = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [IN_TDATA_W-1:0] frame, input bit blk_end,
                              input bit typed, input sample_t want);
        while (!quiet && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= frame;
        s_tlast  <= blk_end;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        downmix_resample(frame, blk_end);
        if (typed) begin
            pending_samples.push_back(want);
        end else begin
            foreach (frame_outputs[k]) begin
                pending_samples.push_back(frame_outputs[k]);
            end
        end
        @(negedge aclk);
    endtask

    // The block may still be busy with a frame that produces no output.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic report(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report("unexpected transfer, mono_out", 0, $signed(m_tdata[15:0]));
            end else begin
                head = pending_samples.pop_front();
                if (m_tdata[15:0] !== head.mono) begin
                    report("mono_out", $signed(head.mono), $signed(m_tdata[15:0]));
                end
                if (m_tdata[34:16] !== head.addr) begin
                    report("ring_address", head.addr, m_tdata[34:16]);
                end
                if (m_tlast !== head.last) begin
                    report("run_last", head.last, m_tlast);
                end
            end
        end
    end

    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= aresetn && (quiet || $urandom_range(0, 99) >= 33);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        bit      busy;
        bit      blk_end;
        sample_t none;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        busy      = 1'b0;
        none      = '0;
        mismatch_count = 0;
        overrun_seen = 1'b0;
        cfg_channels = CC_W'(2);
        cfg_in_rate  = IN_RATE_W'(48000);
        cfg_out_rate = OUT_RATE_W'(16000);
        cfg_capture  = 1'b1;
        mono_prev = 0;
        frame_pos = 0;
        out_pos = 0;
        ring_ptr = 0;
        held_valid = 1'b0;
        held_sample = 0;

        // Reset values first, then each register extreme and each corner case.
        rows.push_back(frame_row(chans(100, -300, 5, 5, 5, 5, 5, 5), 1'b0));
        rows.push_back(frame_row(chans(32767, 32767), 1'b0));
        rows.push_back(frame_row(chans(-32768, 1), 1'b1));
        rows.push_back(cfg_row(REG_IN_RATE, 16000));
        rows.push_back(cfg_row(REG_OUT_RATE, 16000));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 1));
        rows.push_back(frame_row(chans(32767, -32768), 1'b1, 1'b1, 32767, 1));
        rows.push_back(frame_row(chans(-32768, 32767), 1'b1, 1'b1, -32768, 2));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 8));
        rows.push_back(frame_row(all_chans(-32768), 1'b1, 1'b1, -32768, 3));
        rows.push_back(frame_row(all_chans(32767), 1'b1, 1'b1, 32767, 4));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 3));
        rows.push_back(frame_row(chans(-5, 0, 0, 32767, 32767, 32767, 32767, 32767),
                                 1'b1, 1'b1, -1, 5));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 0));
        rows.push_back(frame_row(chans(-7, 1000), 1'b1, 1'b1, -7, 6));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 15));
        rows.push_back(frame_row(all_chans(16384), 1'b1, 1'b1, 16384, 7));
        rows.push_back(cfg_row(REG_CAPTURE_ENABLE, 0));
        rows.push_back(frame_row(chans(1234), 1'b1));
        rows.push_back(cfg_row(REG_CAPTURE_ENABLE, 1));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 2));
        rows.push_back(cfg_row(REG_IN_RATE, 8000));
        rows.push_back(cfg_row(REG_OUT_RATE, 32000));
        rows.push_back(frame_row(chans(-20000, 4000), 1'b0));
        rows.push_back(frame_row(chans(30000, 30001), 1'b0));
        rows.push_back(frame_row(chans(-1, -2), 1'b1));
        rows.push_back(cfg_row(REG_CHANNEL_COUNT, 1));
        rows.push_back(cfg_row(REG_IN_RATE, 0));
        rows.push_back(cfg_row(REG_OUT_RATE, 48000));
        rows.push_back(frame_row(chans(1000), 1'b0));
        rows.push_back(frame_row(chans(-1000), 1'b0));
        rows.push_back(frame_row(chans(32767), 1'b0));
        rows.push_back(frame_row(chans(-32768), 1'b1));
        rows.push_back(cfg_row(REG_OUT_RATE, 0));
        rows.push_back(frame_row(chans(555), 1'b0));
        rows.push_back(frame_row(chans(-555), 1'b1));
        rows.push_back(cfg_row(REG_IN_RATE, 8000));
        rows.push_back(cfg_row(REG_OUT_RATE, 8000));
        rows.push_back(frame_row(chans(100), 1'b0));
        rows.push_back(frame_row(chans(200), 1'b0));
        rows.push_back(frame_row(chans(-300), 1'b0));
        rows.push_back(frame_row(chans(400), 1'b0));
        // A faster output rate in mid-block leaves earlier positions behind.
        rows.push_back(cfg_row(REG_OUT_RATE, 32000));
        rows.push_back(frame_row(chans(-500), 1'b1));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[j]) begin
            if (rows[j].kind == ROW_CFG) begin
                if (busy) begin
                    settle();
                    busy = 1'b0;
                end
                write_reg(rows[j].reg_idx, rows[j].value);
            end else begin
                send_frame(rows[j].frame, rows[j].blk_end, rows[j].typed, rows[j].want);
                busy = 1'b1;
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(REG_CHANNEL_COUNT, ($urandom_range(0, 3) == 0) ?
                      CFG_DATA_W'($urandom_range(0, 15)) : CFG_DATA_W'($urandom_range(1, 8)));
            case ($urandom_range(0, 7))
                0: write_reg(REG_IN_RATE, CFG_DATA_W'(4000));
                1: write_reg(REG_IN_RATE, CFG_DATA_W'(192000));
                2: write_reg(REG_IN_RATE, CFG_DATA_W'($urandom_range(0, 3)));
                3: write_reg(REG_IN_RATE, '1);
                4, 5: write_reg(REG_IN_RATE, CFG_DATA_W'($urandom_range(4000, 16000)));
                default: write_reg(REG_IN_RATE, CFG_DATA_W'($urandom_range(4000, 192000)));
            endcase
            case ($urandom_range(0, 7))
                0: write_reg(REG_OUT_RATE, CFG_DATA_W'(8000));
                1: write_reg(REG_OUT_RATE, CFG_DATA_W'(48000));
                2: write_reg(REG_OUT_RATE, CFG_DATA_W'(16'hFFFF));
                3: write_reg(REG_OUT_RATE, ($urandom_range(0, 2) == 0) ? '0 : CFG_DATA_W'(8000));
                default: write_reg(REG_OUT_RATE, CFG_DATA_W'($urandom_range(8000, 48000)));
            endcase
            write_reg(REG_CAPTURE_ENABLE, CFG_DATA_W'($urandom_range(0, 5) != 0));
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            quiet = (ph == 5 || ph == 6);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // After the first phase one block runs on until it overruns.
                if (ph == 0 || overrun_seen) begin
                    blk_end = ($urandom_range(0, 3) == 0);
                end else begin
                    blk_end = 1'b0;
                end
                send_frame(random_frame(), blk_end, 1'b0, none);
            end
        end

        s_tvalid <= 1'b0;
        quiet = 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_samples.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dlrr_pkg.sv
rtl/dlrr_div.sv
rtl/downmix_linear_resample_ring.sv
tb/tb_downmix_linear_resample_ring.sv
